// ===== src/ibp_pkg.sv =====
// ibp_pkg: shared constants, types and helpers of the index bit packer.
// No dependencies; every other file of the block imports this package.
package ibp_pkg;

	// element and word geometry
	localparam int MAX_ELEMENT_BITS = 25;
	localparam int MIN_ELEMENT_BITS = 8;
	localparam int ELEM_W           = MAX_ELEMENT_BITS;
	localparam int CFG_W            = 5;
	localparam int ACC_W            = 32;
	localparam int CNT_W            = 6;
	localparam int BYTE_W           = 8;
	localparam int NB_W             = 3;

	// configuration port
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam logic [CFG_W-1:0] RST_ELEMENT_BITS = 5'd21;

	// register index, taken from paddr[2]
	typedef enum logic [0:0] {
		REG_ELEMENT_BITS = 1'b0
	} ibp_reg_idx_t;

	// one packed item handed to the byte serializer
	typedef struct packed {
		logic [ACC_W-1:0] word;    // bytes left aligned, first byte in the top bits
		logic [NB_W-1:0]  nbytes;  // 1..4
		logic             last;
	} ibp_pack_t;

	// packer status, used by checks at the top level
	typedef struct packed {
		logic             move;
		logic             last;
		logic [CNT_W-1:0] pend;
		logic [ACC_W-1:0] acc;
	} ibp_stat_t;

	// clamp the programmed width into the legal range
	function automatic logic [CNT_W-1:0] eff_width(input logic [CFG_W-1:0] bits);
		logic [CNT_W-1:0] w;
		w = {1'b0, bits};
		if (w < CNT_W'(MIN_ELEMENT_BITS))
			w = CNT_W'(MIN_ELEMENT_BITS);
		else if (w > CNT_W'(MAX_ELEMENT_BITS))
			w = CNT_W'(MAX_ELEMENT_BITS);
		return w;
	endfunction

endpackage

// ===== src/ibp_in_if.sv =====
// ibp_in_if: input channel of the index bit packer (valid/ready plus element).
// Depends on ibp_pkg for field widths.
interface ibp_in_if;
	import ibp_pkg::*;

	logic              valid;
	logic              ready;
	logic [ELEM_W-1:0] element_value;
	logic              final_element;

	modport source (output valid, output element_value, output final_element, input ready);
	modport sink   (input valid, input element_value, input final_element, output ready);
endinterface

// ===== src/ibp_out_if.sv =====
// ibp_out_if: output channel of the index bit packer (valid/ready plus byte).
// Depends on ibp_pkg for field widths.
interface ibp_out_if;
	import ibp_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] packed_byte;
	logic              final_byte;

	modport source (output valid, output packed_byte, output final_byte, input ready);
	modport sink   (input valid, input packed_byte, input final_byte, output ready);
endinterface

// ===== src/index_bit_packer_top.sv =====
// index_bit_packer_top: top level of the index bit packer.
// Depends on ibp_pkg, ibp_in_if, ibp_out_if, ibp_cfg, ibp_pack, ibp_ser.
//
// Packs the low element_bits bits (8..25, reset 21) of each element into a
// big-endian bit stream and sends it one byte per word on out_ch; the last
// byte produced by an element marked final_element carries final_byte, and
// bits left over after a final element are dropped. Each element yields
// count/8 bytes (1 to 4), where count is the leftover bits plus element_bits;
// the output channel moves one byte per cycle while out_ch.ready holds, and
// input words are taken back to back whenever the byte stream keeps pace.
// An element passes the input register, word holding stage and output
// register before its first byte. element_bits sits at APB address 0; the
// user must write it only while the block is idle; the block does not enforce it.
module index_bit_packer_top (
	input  logic                           clk,
	input  logic                           arst_n,
	ibp_in_if.sink                         in_ch,
	ibp_out_if.source                      out_ch,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ibp_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [ibp_pkg::APB_DATA_W-1:0] pwdata,
	output logic [ibp_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	import ibp_pkg::*;

	logic [CNT_W-1:0] width;
	ibp_pack_t        pack;
	logic             pack_valid;
	logic             pack_take;
	ibp_stat_t        stat;

	ibp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.width   (width)
	);

	ibp_pack u_pack (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.width      (width),
		.pack_o     (pack),
		.pack_valid (pack_valid),
		.pack_take  (pack_take),
		.stat       (stat)
	);

	ibp_ser u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.pack_i     (pack),
		.pack_valid (pack_valid),
		.pack_take  (pack_take),
		.out_ch     (out_ch)
	);

	// leftover bit count never reaches a whole byte
	a_pend_lt_byte: assert property (@(posedge clk) disable iff (!arst_n)
		stat.pend < CNT_W'(BYTE_W))
		else $error("leftover bit count reached a full byte");

	// accumulator holds no bits above the leftover count
	a_acc_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.acc >> stat.pend) == '0)
		else $error("accumulator has stale bits above leftover count");

	// a final element empties the accumulator
	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		stat.move && stat.last |=> stat.pend == '0 && stat.acc == '0)
		else $error("accumulator not cleared after final element");
endmodule

// ===== src/ibp_cfg.sv =====
// ibp_cfg: APB-style register file holding element_bits.
// Depends on ibp_pkg; drives the clamped width to the packer.
module ibp_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ibp_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [ibp_pkg::APB_DATA_W-1:0] pwdata,
	output logic [ibp_pkg::APB_DATA_W-1:0] prdata,
	output logic                          pready,
	output logic [ibp_pkg::CNT_W-1:0]      width
);
	import ibp_pkg::*;

	logic [CFG_W-1:0] element_bits_q;
	ibp_reg_idx_t     idx;
	logic             wr_en;

	assign idx    = ibp_reg_idx_t'(paddr[2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (idx == REG_ELEMENT_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_bits_q <= RST_ELEMENT_BITS;
		end else if (wr_en) begin
			element_bits_q <= pwdata[CFG_W-1:0];
		end
	end

	// read back
	always_comb begin
		unique case (idx)
			REG_ELEMENT_BITS: prdata = APB_DATA_W'(element_bits_q);
			default:          prdata = '0;
		endcase
	end

	assign width = eff_width(element_bits_q);
endmodule

// ===== src/ibp_pack.sv =====
// ibp_pack: input register and bit accumulator; merges each element with the
// leftover bits and hands a left-aligned word of whole bytes on. Uses ibp_pkg, ibp_in_if.
module ibp_pack (
	input  logic                     clk,
	input  logic                     arst_n,
	ibp_in_if.sink                   in_ch,
	input  logic [ibp_pkg::CNT_W-1:0] width,
	output ibp_pkg::ibp_pack_t       pack_o,
	output logic                     pack_valid,
	input  logic                     pack_take,
	output ibp_pkg::ibp_stat_t       stat
);
	import ibp_pkg::*;

	logic              valid_s1;
	logic [ELEM_W-1:0] value_s1;
	logic              last_s1;

	logic [ACC_W-1:0]   acc_q;
	logic [CNT_W-1:0]   pend_q;

	logic [ACC_W-1:0]   mask;
	logic [2*ACC_W-1:0] full_w;
	logic [ACC_W-1:0]   full;
	logic [CNT_W-1:0]   count;
	logic [2:0]         rem;
	logic [ACC_W-1:0]   acc_nxt;
	logic               move;

	assign move        = valid_s1 && pack_take;
	assign in_ch.ready = !valid_s1 || pack_take;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			value_s1 <= in_ch.element_value;
			last_s1  <= in_ch.final_element;
		end
	end

	// append the masked element below the leftover bits
	always_comb begin
		mask    = (ACC_W'(1) << width) - ACC_W'(1);
		full_w  = ({{ACC_W{1'b0}}, acc_q} << width)
		        | (2*ACC_W)'(value_s1 & mask[ELEM_W-1:0]);
		full    = full_w[ACC_W-1:0];
		count   = pend_q + width;
		rem     = count[2:0];
		acc_nxt = full & ((ACC_W'(1) << rem) - ACC_W'(1));
	end

	assign pack_valid    = valid_s1;
	assign pack_o.word   = full << (CNT_W'(ACC_W) - count);
	assign pack_o.nbytes = count[CNT_W-1:3];
	assign pack_o.last   = last_s1;

	// leftover bits; a final element drops them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pend_q <= '0;
		end else if (move) begin
			if (last_s1) begin
				acc_q  <= '0;
				pend_q <= '0;
			end else begin
				acc_q  <= acc_nxt;
				pend_q <= CNT_W'(rem);
			end
		end
	end

	assign stat.move = move;
	assign stat.last = last_s1;
	assign stat.pend = pend_q;
	assign stat.acc  = acc_q;
endmodule

// ===== src/ibp_ser.sv =====
// ibp_ser: holds one packed word and sends its bytes, first byte first,
// through an output register. Uses ibp_pkg, ibp_out_if.
module ibp_ser (
	input  logic               clk,
	input  logic               arst_n,
	input  ibp_pkg::ibp_pack_t pack_i,
	input  logic               pack_valid,
	output logic               pack_take,
	ibp_out_if.source          out_ch
);
	import ibp_pkg::*;

	logic [ACC_W-1:0]  word_s2;
	logic [NB_W-1:0]   left_s2;
	logic              last_s2;
	logic              valid_s2;

	logic              valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              fbyte_q;

	logic out_load;
	logic emit;
	logic s2_done;

	assign out_load  = !valid_q || out_ch.ready;
	assign emit      = valid_s2 && out_load;
	assign s2_done   = emit && (left_s2 == NB_W'(1));
	assign pack_take = pack_valid && (!valid_s2 || s2_done);

	// word holding stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (pack_take) begin
			valid_s2 <= 1'b1;
		end else if (s2_done) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pack_take) begin
			word_s2 <= pack_i.word;
			left_s2 <= pack_i.nbytes;
			last_s2 <= pack_i.last;
		end else if (emit) begin
			word_s2 <= word_s2 << BYTE_W;
			left_s2 <= left_s2 - NB_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_load) begin
			valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q  <= word_s2[ACC_W-1 -: BYTE_W];
			fbyte_q <= last_s2 && (left_s2 == NB_W'(1));
		end
	end

	assign out_ch.valid       = valid_q;
	assign out_ch.packed_byte = byte_q;
	assign out_ch.final_byte  = fbyte_q;
endmodule
